// ===== sv/plb_pkg.sv =====
// Shared types, constants and codes of the pixel layer blend pipeline.
`default_nettype none
package plb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 24;

  localparam logic [16:0] ONE17  = 17'h10000;
  localparam logic [16:0] HALF17 = 17'h08000;

  // Divider: numerator width, quotient bits per stage, stage count
  localparam int DIV_W      = 36;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;
  localparam int DEN_W      = 17;

  localparam logic [2:0] CFG_BLEND_MODE       = 3'd0;
  localparam logic [2:0] CFG_REVERSE_OPERANDS = 3'd1;
  localparam logic [2:0] CFG_INVERT_MASK      = 3'd2;
  localparam logic [2:0] CFG_GLOBAL_OPACITY   = 3'd3;
  localparam logic [2:0] CFG_SHOW_MASK_ONLY   = 3'd4;

  typedef enum logic [3:0] {
    MODE_NORMAL       = 4'd0,
    MODE_NORMAL_CLAMP = 4'd1,
    MODE_LIGHTEN      = 4'd2,
    MODE_DARKEN       = 4'd3,
    MODE_MULTIPLY     = 4'd4,
    MODE_AVERAGE      = 4'd5,
    MODE_ADD          = 4'd6,
    MODE_SUBTRACT     = 4'd7,
    MODE_DIFFERENCE   = 4'd8,
    MODE_SCREEN       = 4'd9,
    MODE_OVERLAY      = 4'd10,
    MODE_SOFTLIGHT    = 4'd11,
    MODE_HARDLIGHT    = 4'd12,
    MODE_VIVIDLIGHT   = 4'd13,
    MODE_LINEARLIGHT  = 4'd14,
    MODE_PINLIGHT     = 4'd15
  } mode_e;

  // Source of the mode function value
  typedef enum logic [2:0] {
    FSEL_DIRECT  = 3'd0,
    FSEL_MUL     = 3'd1,
    FSEL_MUL_INV = 3'd2,
    FSEL_DIV     = 3'd3,
    FSEL_DIV_INV = 3'd4
  } fsel_e;

  typedef struct packed {
    mode_e       mode;
    logic        reverse;
    logic        invert;
    logic [16:0] gop;
    logic        show;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic               show;
    logic signed [23:0] a;
    logic [16:0]        la;
    logic [16:0]        op;
    logic signed [25:0] mx;
    logic signed [25:0] my;
    fsel_e              fsel;
    logic signed [25:0] fd;
  } side_t;

endpackage
`default_nettype wire

// ===== sv/plb_front.sv =====
// Front stages: opacity product, operand clamp, mode function setup.
`default_nettype none
module plb_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [23:0] base_i,
  input  wire logic signed [23:0] layer_i,
  input  wire logic [16:0]        mask_i,
  input  wire plb_pkg::cfg_t      cfg_i,
  output logic                    valid_o,
  output plb_pkg::side_t          side_o,
  output logic [plb_pkg::DIV_W-1:0] num_o,
  output logic [plb_pkg::DEN_W-1:0] den_o
);

  logic               v1_q;
  logic signed [23:0] a1_q, b1_q;
  logic [33:0]        pm1_q;
  plb_pkg::mode_e     mode1_q;
  logic               show1_q;

  logic [16:0] mc, gc;

  always_comb begin
    mc = (mask_i > plb_pkg::ONE17) ? plb_pkg::ONE17 : mask_i;
    gc = (cfg_i.gop > plb_pkg::ONE17) ? plb_pkg::ONE17 : cfg_i.gop;
    if (cfg_i.invert) begin
      mc = plb_pkg::ONE17 - mc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= cfg_i.reverse ? layer_i : base_i;
      b1_q    <= cfg_i.reverse ? base_i : layer_i;
      pm1_q   <= gc * mc;
      mode1_q <= cfg_i.mode;
      show1_q <= cfg_i.show;
    end
  end

  localparam logic signed [25:0] ONE26  = 26'sd65536;
  localparam logic signed [25:0] HALF26 = 26'sd32768;

  plb_pkg::side_t            side_d;
  logic [plb_pkg::DIV_W-1:0] num_d;
  logic [plb_pkg::DEN_W-1:0] den_d;
  logic [16:0]               la, lb;
  logic signed [25:0]        a26, b26, la26, lb26, t26;

  always_comb begin
    if (a1_q < 0) la = '0;
    else if (a1_q > 24'sd65536) la = plb_pkg::ONE17;
    else la = a1_q[16:0];
    if (b1_q < 0) lb = '0;
    else if (b1_q > 24'sd65536) lb = plb_pkg::ONE17;
    else lb = b1_q[16:0];
    a26  = 26'(a1_q);
    b26  = 26'(b1_q);
    la26 = signed'({9'b0, la});
    lb26 = signed'({9'b0, lb});
    t26  = '0;

    side_d.mode = mode1_q;
    side_d.show = show1_q;
    side_d.a    = a1_q;
    side_d.la   = la;
    side_d.op   = 17'((pm1_q + 34'd32768) >> 16);
    side_d.mx   = '0;
    side_d.my   = '0;
    side_d.fsel = plb_pkg::FSEL_DIRECT;
    side_d.fd   = b26;
    num_d       = '0;
    den_d       = 17'd1;

    case (mode1_q)
      plb_pkg::MODE_NORMAL, plb_pkg::MODE_NORMAL_CLAMP: side_d.fd = b26;
      plb_pkg::MODE_LIGHTEN:    side_d.fd = (a26 > b26) ? a26 : b26;
      plb_pkg::MODE_DARKEN:     side_d.fd = (a26 < b26) ? a26 : b26;
      plb_pkg::MODE_MULTIPLY: begin
        side_d.mx   = a26;
        side_d.my   = b26;
        side_d.fsel = plb_pkg::FSEL_MUL;
      end
      plb_pkg::MODE_AVERAGE:    side_d.fd = (a26 + b26 + 26'sd1) >>> 1;
      plb_pkg::MODE_ADD:        side_d.fd = a26 + b26;
      plb_pkg::MODE_SUBTRACT:   side_d.fd = a26 + b26 - ONE26;
      plb_pkg::MODE_DIFFERENCE: side_d.fd = (a26 > b26) ? a26 - b26 : b26 - a26;
      plb_pkg::MODE_SCREEN: begin
        side_d.mx   = ONE26 - la26;
        side_d.my   = ONE26 - lb26;
        side_d.fsel = plb_pkg::FSEL_MUL_INV;
      end
      plb_pkg::MODE_OVERLAY, plb_pkg::MODE_HARDLIGHT: begin
        if (((mode1_q == plb_pkg::MODE_OVERLAY) ? la26 : lb26) > HALF26) begin
          side_d.mx   = ONE26 - ((la26 - HALF26) <<< 1);
          side_d.my   = ONE26 - lb26;
          side_d.fsel = plb_pkg::FSEL_MUL_INV;
        end else begin
          side_d.mx   = la26 <<< 1;
          side_d.my   = lb26;
          side_d.fsel = plb_pkg::FSEL_MUL;
        end
      end
      plb_pkg::MODE_SOFTLIGHT: begin
        if (lb26 > HALF26) begin
          side_d.mx   = ONE26 - la26;
          side_d.my   = ONE26 - (lb26 - HALF26);
          side_d.fsel = plb_pkg::FSEL_MUL_INV;
        end else begin
          side_d.mx   = la26;
          side_d.my   = lb26 + HALF26;
          side_d.fsel = plb_pkg::FSEL_MUL;
        end
      end
      plb_pkg::MODE_VIVIDLIGHT: begin
        if (lb26 > HALF26) begin
          if (lb26 >= ONE26) begin
            side_d.fd = ONE26;
          end else begin
            // dodge half: (la << 16 + den/2) / den, den = 2 * (one - lb)
            num_d       = {3'b0, la, 16'b0} + 36'(plb_pkg::ONE17 - lb);
            den_d       = 17'((18'(plb_pkg::ONE17) - 18'(lb)) << 1);
            side_d.fsel = plb_pkg::FSEL_DIV;
          end
        end else begin
          if (lb26 <= 26'sd0) begin
            side_d.fd = '0;
          end else begin
            // burn half: one - ((one - la) << 16 + lb) / (2 * lb)
            num_d       = {3'b0, plb_pkg::ONE17 - la, 16'b0} + 36'(lb);
            den_d       = 17'(18'(lb) << 1);
            side_d.fsel = plb_pkg::FSEL_DIV_INV;
          end
        end
      end
      plb_pkg::MODE_LINEARLIGHT: side_d.fd = la26 + (lb26 <<< 1) - ONE26;
      plb_pkg::MODE_PINLIGHT: begin
        if (lb26 > HALF26) begin
          t26       = (lb26 - HALF26) <<< 1;
          side_d.fd = (la26 > t26) ? la26 : t26;
        end else begin
          t26       = lb26 <<< 1;
          side_d.fd = (la26 < t26) ? la26 : t26;
        end
      end
      default: side_d.fd = b26;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_d;
      num_o  <= num_d;
      den_o  <= den_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/plb_div.sv =====
// Pipelined restoring divider for the vivid light mode, side data alongside.
`default_nettype none
module plb_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire plb_pkg::side_t              side_i,
  input  wire logic [plb_pkg::DIV_W-1:0]   num_i,
  input  wire logic [plb_pkg::DEN_W-1:0]   den_i,
  output logic                             valid_o,
  output plb_pkg::side_t                   side_o,
  output logic [31:0]                      quo_o
);

  localparam int NS = plb_pkg::DIV_STAGES;
  localparam int NW = plb_pkg::DIV_W;
  localparam int DW = plb_pkg::DEN_W;

  logic [NS-1:0]   v_q;
  plb_pkg::side_t  side_q [NS];
  logic [NW-1:0]   num_q  [NS];
  logic [NW-1:0]   quo_q  [NS];
  logic [DW-1:0]   rem_q  [NS];
  logic [DW-1:0]   den_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic           v_in;
    plb_pkg::side_t side_in;
    logic [NW-1:0]  n_in, q_in, n_d, q_d;
    logic [DW-1:0]  r_in, d_in, r_d;
    logic [DW:0]    r_sh;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign n_in    = num_i;
      assign q_in    = '0;
      assign r_in    = '0;
      assign d_in    = den_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
      assign n_in    = num_q[s-1];
      assign q_in    = quo_q[s-1];
      assign r_in    = rem_q[s-1];
      assign d_in    = den_q[s-1];
    end

    always_comb begin
      n_d  = n_in;
      q_d  = q_in;
      r_d  = r_in;
      r_sh = '0;
      for (int k = 0; k < plb_pkg::DIV_BITS; k++) begin
        r_sh = {r_d, n_d[NW-1]};
        n_d  = {n_d[NW-2:0], 1'b0};
        if (r_sh >= {1'b0, d_in}) begin
          r_sh = r_sh - {1'b0, d_in};
          q_d  = {q_d[NW-2:0], 1'b1};
        end else begin
          q_d  = {q_d[NW-2:0], 1'b0};
        end
        r_d = r_sh[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        num_q[s]  <= n_d;
        quo_q[s]  <= q_d;
        rem_q[s]  <= r_d;
        den_q[s]  <= d_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign quo_o   = quo_q[NS-1][31:0];

endmodule
`default_nettype wire

// ===== sv/plb_back.sv =====
// Back stages: mode product, opacity mix, clamp and saturation, output register.
`default_nettype none
module plb_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire plb_pkg::side_t     side_i,
  input  wire logic [31:0]        quo_i,
  output logic                    valid_o,
  output logic signed [23:0]      pixel_o
);

  localparam logic signed [33:0] ONE34 = 34'sd65536;

  // B1: mode product and opacity square
  logic               v1_q;
  logic signed [51:0] mp1_q;
  logic [33:0]        pp1_q;
  logic [31:0]        quo1_q;
  plb_pkg::side_t     side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mp1_q   <= side_i.mx * side_i.my;
      pp1_q   <= side_i.op * side_i.op;
      quo1_q  <= quo_i;
      side1_q <= side_i;
    end
  end

  // B2: pick the mode value and the opacity, form f - A
  logic signed [51:0] mt;
  logic signed [33:0] mr, f;
  logic signed [25:0] a_sel;
  logic [16:0]        op2, op_sel;
  logic               hi;

  always_comb begin
    mt  = mp1_q + 52'sd32768;
    mr  = 34'(mt >>> 16);
    op2 = 17'((pp1_q + 34'd32768) >> 16);
    case (side1_q.fsel)
      plb_pkg::FSEL_MUL:     f = mr;
      plb_pkg::FSEL_MUL_INV: f = ONE34 - mr;
      plb_pkg::FSEL_DIV:     f = signed'({2'b00, quo1_q});
      plb_pkg::FSEL_DIV_INV: f = ONE34 - signed'({2'b00, quo1_q});
      default:               f = 34'(side1_q.fd);
    endcase
    hi     = (side1_q.mode >= plb_pkg::MODE_SCREEN);
    a_sel  = hi ? signed'({9'b0, side1_q.la}) : 26'(side1_q.a);
    op_sel = hi ? op2 : side1_q.op;
  end

  logic               v2_q;
  logic signed [34:0] d2_q;
  logic [16:0]        op2_q;
  logic signed [25:0] a2_q;
  logic               clamp2_q, show2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q     <= 35'(f) - 35'(a_sel);
      op2_q    <= op_sel;
      a2_q     <= a_sel;
      clamp2_q <= (side1_q.mode != plb_pkg::MODE_NORMAL);
      show2_q  <= side1_q.show;
    end
  end

  // B3: scale the difference by the opacity
  logic               v3_q;
  logic signed [52:0] prod3_q;
  logic signed [25:0] a3_q;
  logic               clamp3_q, show3_q;
  logic signed [17:0] op_s;

  assign op_s = signed'({1'b0, op2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod3_q  <= d2_q * op_s;
      a3_q     <= a2_q;
      clamp3_q <= clamp2_q;
      show3_q  <= show2_q;
    end
  end

  // B4: round, add back, clamp or saturate, zero when show mask is set, into the output register
  logic signed [52:0] pt;
  logic signed [37:0] r;
  logic signed [23:0] pix_d;

  always_comb begin
    pt = prod3_q + 53'sd32768;
    r  = 38'(pt >>> 16) + 38'(a3_q);
    if (clamp3_q) begin
      if (r < 38'sd0) r = '0;
      else if (r > 38'sd65536) r = 38'sd65536;
    end
    if (r > 38'sd8388607) pix_d = 24'sh7FFFFF;
    else if (r < -38'sd8388608) pix_d = 24'sh800000;
    else pix_d = r[23:0];
    if (show3_q) pix_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_o <= pix_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pixel_layer_blend.sv =====
// Top level of the pixel layer blend: config registers, stall control, pipeline.
// Usage:
//   Input stream (s_axis_*): one transfer carries a base pixel, a layer pixel
//   and a mask value; all pixels are signed Q8.16, the mask unsigned Q1.16.
//   Output stream (m_axis_*): one blended Q8.16 pixel per input transfer, in
//   order. Each pixel is independent, so one transfer is taken per cycle
//   while not stalled. Pipeline: two front stages, nine divider stages of
//   four quotient bits, four back stages.
//   Throughput: one pixel per cycle while not stalled; the nine-stage divider
//   for vivid light sets the depth, not the rate.
//   Stall: the whole pipeline advances only while the output register is
//   empty or being taken; s_axis_tready drops exactly when a held result
//   waits, so nothing is lost or repeated.
//   Configuration: write cfg_we_i/cfg_idx_i/cfg_data_i while the pipeline is
//   empty; registers are blend mode, reverse operands, invert mask, global
//   opacity and show mask only, in index order.
//   Reset: clears every valid bit and returns the registers to normal mode,
//   no reverse, no inversion, full opacity, mask display off.
`default_nettype none
module pixel_layer_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [23:0] base_pixel, [47:24] layer_pixel, [64:48] mask_value, [71:65] zero
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] blended_pixel
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  plb_pkg::cfg_t cfg_q;

  // Hold configuration; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= plb_pkg::MODE_NORMAL;
      cfg_q.reverse <= 1'b0;
      cfg_q.invert  <= 1'b0;
      cfg_q.gop     <= plb_pkg::ONE17;
      cfg_q.show    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plb_pkg::CFG_BLEND_MODE:       cfg_q.mode    <= plb_pkg::mode_e'(cfg_data_i[3:0]);
        plb_pkg::CFG_REVERSE_OPERANDS: cfg_q.reverse <= cfg_data_i[0];
        plb_pkg::CFG_INVERT_MASK:      cfg_q.invert  <= cfg_data_i[0];
        plb_pkg::CFG_GLOBAL_OPACITY:   cfg_q.gop     <= cfg_data_i;
        plb_pkg::CFG_SHOW_MASK_ONLY:   cfg_q.show    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance every stage together unless a result is held at the output
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic                      fv;
  plb_pkg::side_t            fside;
  logic [plb_pkg::DIV_W-1:0] fnum;
  logic [plb_pkg::DEN_W-1:0] fden;

  plb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .base_i  (signed'(s_axis_tdata[23:0])),
    .layer_i (signed'(s_axis_tdata[47:24])),
    .mask_i  (s_axis_tdata[64:48]),
    .cfg_i   (cfg_q),
    .valid_o (fv),
    .side_o  (fside),
    .num_o   (fnum),
    .den_o   (fden)
  );

  logic           dv;
  plb_pkg::side_t dside;
  logic [31:0]    dquo;

  plb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .side_i  (fside),
    .num_i   (fnum),
    .den_i   (fden),
    .valid_o (dv),
    .side_o  (dside),
    .quo_o   (dquo)
  );

  logic signed [23:0] pix;

  plb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .side_i  (dside),
    .quo_i   (dquo),
    .valid_o (m_axis_tvalid),
    .pixel_o (pix)
  );

  assign m_axis_tdata = pix;

endmodule
`default_nettype wire
